// ===== sv/random_replacement_key_cache_core_defines.svh =====
// ----------------------------------------------------------------------------
// random_replacement_key_cache_core_defines
// assertion macros used by the key cache datapath
// ----------------------------------------------------------------------------
`ifndef RANDOM_REPLACEMENT_KEY_CACHE_CORE_DEFINES_SVH
`define RANDOM_REPLACEMENT_KEY_CACHE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RRKC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RRKC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rrkc_pkg.sv =====
// ----------------------------------------------------------------------------
// rrkc_pkg
// shared types and constants of the random replacement key cache
// ----------------------------------------------------------------------------
package rrkc_pkg;

    localparam int KEY_W        = 16;
    localparam int PICK_W       = 16;
    localparam int CAP_W        = 5;
    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PICK_W-1:0] random_pick;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic search;
        logic rd_vic;
        logic rd_last;
        logic wr_vic;
        logic wr_last;
        logic wr_ins;
        logic ret;
        logic ret_evict;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic hit;
        logic cap_zero;
        logic need_evict;
        logic div_done;
        logic out_busy;
    } dp_sts_t;

endpackage

// ===== sv/rrkc_ram.sv =====
// ----------------------------------------------------------------------------
// rrkc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rrkc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/rrkc_mod.sv =====
// ----------------------------------------------------------------------------
// rrkc_mod
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module rrkc_mod #(
    parameter int DIVISOR_W = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rrkc_pkg::PICK_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0]           divisor,
    output logic [DIVISOR_W-1:0]           rem,
    output logic                           done
);

    localparam int CNT_W = $clog2(rrkc_pkg::PICK_W + 1);
    localparam int REM_W = DIVISOR_W + 1;

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [rrkc_pkg::PICK_W-1:0]   dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]          dvs_reg, dvs_next;
    logic [DIVISOR_W-1:0]          rem_reg, rem_next;
    logic [REM_W-1:0]              rem_sh;
    logic [REM_W-1:0]              dvs_ext;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[rrkc_pkg::PICK_W-1]};
        dvs_ext  = {1'b0, dvs_reg};
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(rrkc_pkg::PICK_W);
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            // shift in next dividend bit, subtract when it fits
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= dvs_ext)
            begin
                rem_next = DIVISOR_W'(rem_sh - dvs_ext);
            end
            else
            begin
                rem_next = DIVISOR_W'(rem_sh);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rem  = rem_reg;
    assign done = (cnt_reg == '0);

endmodule

// ===== sv/rrkc_dp.sv =====
// ----------------------------------------------------------------------------
// rrkc_dp
// key cache datapath: key store, fill count, scan, victim remainder, result
// ----------------------------------------------------------------------------
`include "random_replacement_key_cache_core_defines.svh"

module rrkc_dp #(
    parameter int ENTRIES  = rrkc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = rrkc_pkg::KEY_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rrkc_pkg::dp_cmd_t               cmd,
    output rrkc_pkg::dp_sts_t               sts,
    input  logic                            in_fire,
    input  rrkc_pkg::req_t                  in_req,
    input  logic                            cfg_we,
    input  logic [rrkc_pkg::CAP_W-1:0]      cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rrkc_pkg::rsp_t                  out_rsp
);

    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CMP_W  = (FILL_W > rrkc_pkg::CAP_W) ? FILL_W : rrkc_pkg::CAP_W;

    logic [rrkc_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [FILL_W-1:0]          idx_reg, idx_next;
    logic                       pend_reg, pend_next;
    logic                       hit_reg, hit_next;
    logic                       out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0]        key_reg, key_next;
    logic [KEY_BITS-1:0]        evkey_reg, evkey_next;
    rrkc_pkg::rsp_t             rsp_reg, rsp_next;

    logic [CMP_W-1:0]           cap_ext, ent_ext, cap_eff, fill_ext;
    logic                       idx_lt;
    logic [FILL_W-1:0]          last;
    logic [FILL_W-1:0]          victim;
    logic                       div_done;

    logic                       ram_we, ram_re;
    logic [IDX_W-1:0]           ram_waddr, ram_raddr;
    logic [KEY_BITS-1:0]        ram_wdata, ram_rdata;

    // capacity saturates at the store depth
    assign cap_ext  = CMP_W'(cap_reg);
    assign ent_ext  = CMP_W'(ENTRIES);
    assign cap_eff  = (cap_ext > ent_ext) ? ent_ext : cap_ext;
    assign fill_ext = CMP_W'(fill_reg);
    assign idx_lt   = (idx_reg < fill_reg);
    assign last     = fill_reg - 1'b1;

    rrkc_mod #(
        .DIVISOR_W (FILL_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (in_req.random_pick),
        .divisor  (fill_reg),
        .rem      (victim),
        .done     (div_done)
    );

    rrkc_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        ram_re    = (cmd.search && idx_lt) || cmd.rd_vic || cmd.rd_last;
        ram_raddr = IDX_W'(idx_reg);
        priority if (cmd.rd_vic)
        begin
            ram_raddr = IDX_W'(victim);
        end
        else if (cmd.rd_last)
        begin
            ram_raddr = IDX_W'(last);
        end

        ram_we    = cmd.wr_vic || cmd.wr_last || cmd.wr_ins;
        ram_wdata = key_reg;
        ram_waddr = IDX_W'(fill_reg);
        priority if (cmd.wr_vic)
        begin
            // last slot's key moves into the victim slot
            ram_waddr = IDX_W'(victim);
            ram_wdata = ram_rdata;
        end
        else if (cmd.wr_last)
        begin
            ram_waddr = IDX_W'(last);
        end
    end

    always_comb
    begin
        cap_next       = cfg_we ? cfg_data : cap_reg;
        fill_next      = cmd.wr_ins ? fill_reg + 1'b1 : fill_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        hit_next       = hit_reg || (pend_reg && (ram_rdata == key_reg));
        key_next       = key_reg;
        evkey_next     = cmd.rd_last ? ram_rdata : evkey_reg;
        rsp_next       = rsp_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (in_fire)
        begin
            key_next = KEY_BITS'(in_req.key);
        end
        if (cmd.load)
        begin
            idx_next = '0;
            hit_next = 1'b0;
        end
        else if (cmd.search && idx_lt)
        begin
            idx_next  = idx_reg + 1'b1;
            pend_next = 1'b1;
        end

        if (cmd.ret)
        begin
            rsp_next.hit         = hit_reg;
            rsp_next.evicted     = cmd.ret_evict;
            rsp_next.evicted_key = cmd.ret_evict ? rrkc_pkg::KEY_W'(evkey_reg) : '0;
            out_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= rrkc_pkg::CAP_RESET;
            fill_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        evkey_reg <= evkey_next;
        rsp_reg   <= rsp_next;
    end

    always_comb
    begin
        sts.scan_done  = hit_reg || (!pend_reg && (idx_reg == fill_reg));
        sts.hit        = hit_reg;
        sts.cap_zero   = (cap_eff == '0);
        sts.need_evict = (fill_ext >= cap_eff) && (fill_reg != '0);
        sts.div_done   = div_done;
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = rsp_reg;

    `RRKC_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(ENTRIES), "fill count above depth")
    `RRKC_ASSERT_NOW(a_victim_range, cmd.rd_vic, victim < fill_reg, "victim outside filled slots")
    `RRKC_ASSERT_NEXT(a_ins_grow, cmd.wr_ins, fill_reg == $past(fill_reg) + 1'b1, "insert lost")
    `RRKC_ASSERT_NOW(a_ret_free, cmd.ret, !sts.out_busy, "result overwrote waiting response")

endmodule

// ===== sv/rrkc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrkc_ctrl
// key cache controller: scan, evict, insert and respond sequencing
// ----------------------------------------------------------------------------
module rrkc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output rrkc_pkg::dp_cmd_t cmd,
    input  rrkc_pkg::dp_sts_t sts
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SEARCH  = 4'd1;
    localparam logic [3:0] ST_DIVWAIT = 4'd2;
    localparam logic [3:0] ST_RD_VIC  = 4'd3;
    localparam logic [3:0] ST_RD_LAST = 4'd4;
    localparam logic [3:0] ST_WR_VIC  = 4'd5;
    localparam logic [3:0] ST_WR_LAST = 4'd6;
    localparam logic [3:0] ST_WR_INS  = 4'd7;
    localparam logic [3:0] ST_RESULT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       evict_reg, evict_next;

    always_comb
    begin
        state_next = state_reg;
        evict_next = evict_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    evict_next = 1'b0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.scan_done)
                begin
                    priority if (sts.hit || sts.cap_zero)
                    begin
                        state_next = ST_RESULT;
                    end
                    else if (sts.need_evict)
                    begin
                        evict_next = 1'b1;
                        state_next = ST_DIVWAIT;
                    end
                    else
                    begin
                        state_next = ST_WR_INS;
                    end
                end
            end
            ST_DIVWAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_RD_VIC;
                end
            end
            ST_RD_VIC:
            begin
                cmd.rd_vic = 1'b1;
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                cmd.rd_last = 1'b1;
                state_next  = ST_WR_VIC;
            end
            ST_WR_VIC:
            begin
                cmd.wr_vic = 1'b1;
                state_next = ST_WR_LAST;
            end
            ST_WR_LAST:
            begin
                cmd.wr_last = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_WR_INS:
            begin
                cmd.wr_ins = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.ret       = 1'b1;
                    cmd.ret_evict = evict_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            evict_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            evict_reg <= evict_next;
        end
    end

endmodule

// ===== sv/random_replacement_key_cache_core.sv =====
// ----------------------------------------------------------------------------
// random_replacement_key_cache_core
// fully associative key store with random victim replacement
// ----------------------------------------------------------------------------
// One request at a time: a request is taken in idle, the filled slots are
// scanned one per cycle through the key ram's registered read port, and a
// hit or a store with capacity zero answers after the scan. A miss below
// capacity appends the key with one write. A miss at or above capacity
// evicts: the victim slot is random_pick modulo the fill count, worked out
// by a bit-serial remainder unit that starts when the request is taken and
// runs alongside the scan; a wait state holds until the remainder is done,
// then the victim and the last slot are read and the last key moved into
// the victim slot, and the new key is written to the last slot. The
// response sits in an output register, so a new request is taken while the
// previous response still waits.
// ----------------------------------------------------------------------------
module random_replacement_key_cache_core #(
    parameter int ENTRIES  = rrkc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = rrkc_pkg::KEY_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rrkc_pkg::req_t              in_req,
    // response channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output rrkc_pkg::rsp_t              out_rsp,
    // capacity register write
    input  logic                        cfg_we,
    input  logic [rrkc_pkg::CAP_W-1:0]  cfg_data
);

    rrkc_pkg::dp_cmd_t cmd;
    rrkc_pkg::dp_sts_t sts;
    logic              in_fire;

    // request taken on handshake
    assign in_fire = in_valid && in_ready;

    // sequencing of scan, eviction and insert
    rrkc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // key ram, fill count, remainder unit and response register
    rrkc_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_fire   (in_fire),
        .in_req    (in_req),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp)
    );

endmodule

// ===== tb/random_replacement_key_cache_core_test.sv =====
// ----------------------------------------------------------------------------
// random_replacement_key_cache_core_test
// self-checking bench for the random replacement key cache
// ----------------------------------------------------------------------------
// Drives requests over the valid/ready request channel and keeps its own
// model of the key store (filled slots, fill count, capacity). Every accepted
// request is turned into one expected response and queued. Responses are
// compared in order against that queue. A directed run covers hits, misses,
// key and pick extremes, capacity zero, capacity above the slot count, a
// capacity lowered below the fill count and a victim in the last slot. The
// random part then runs three idling profiles with frequent capacity changes.
// ----------------------------------------------------------------------------
module random_replacement_key_cache_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = rrkc_pkg::ENTRIES_DEF;
    localparam int CHUNK_ITEMS = 42;
    localparam int CHUNKS      = 6;
    localparam int POOL_MAX    = 24;
    // worst case per request is the block's eviction sequence plus long sender
    // gaps and receiver stalls; the limit leaves a wide margin
    localparam int CYCLE_LIMIT = 400000;

    // ------------------------------------------------------------------------
    // scoreboard: model of the key store plus the queue of expected responses
    // ------------------------------------------------------------------------
    class key_cache_scoreboard;
        logic [rrkc_pkg::KEY_W-1:0] stored_keys[SLOTS];
        int unsigned                fill;
        logic [rrkc_pkg::CAP_W-1:0] capacity;
        rrkc_pkg::rsp_t             expected_rsp[$];
        int unsigned                mismatches;

        function new();
            fill       = 0;
            capacity   = rrkc_pkg::CAP_RESET;
            mismatches = 0;
        endfunction

        // work out the response of one accepted request and update the store
        function void note_request(rrkc_pkg::req_t r);
            rrkc_pkg::rsp_t want;
            int unsigned    limit;
            int unsigned    victim;
            bit             found;
            want   = '0;
            found  = 1'b0;
            limit  = (capacity > SLOTS) ? SLOTS : capacity;
            for (int i = 0; i < fill; i++)
            begin
                if (stored_keys[i] == r.key)
                    found = 1'b1;
            end
            if (found)
            begin
                want.hit = 1'b1;
            end
            else if (limit != 0)
            begin
                // store at or over capacity: drop one key, last slot fills the gap
                if (fill >= limit && fill != 0)
                begin
                    victim              = r.random_pick % fill;
                    want.evicted        = 1'b1;
                    want.evicted_key    = stored_keys[victim];
                    stored_keys[victim] = stored_keys[fill-1];
                    fill                = fill - 1;
                end
                if (fill < SLOTS)
                begin
                    stored_keys[fill] = r.key;
                    fill              = fill + 1;
                end
            end
            expected_rsp = {expected_rsp, want};
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_response(rrkc_pkg::rsp_t got);
            rrkc_pkg::rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                report_mismatch($sformatf("response with no request outstanding (hit %b ev %b key %h)",
                                          got.hit, got.evicted, got.evicted_key));
                return;
            end
            want = expected_rsp.pop_front();
            if (got.hit !== want.hit)
                report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
            if (got.evicted !== want.evicted)
                report_mismatch($sformatf("evicted %b, expected %b", got.evicted, want.evicted));
            if (got.evicted_key !== want.evicted_key)
                report_mismatch($sformatf("evicted_key %h, expected %h",
                                          got.evicted_key, want.evicted_key));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    rrkc_pkg::req_t             in_req;
    logic                       out_valid;
    logic                       out_ready;
    rrkc_pkg::rsp_t             out_rsp;
    logic                       cfg_we;
    logic [rrkc_pkg::CAP_W-1:0] cfg_data;

    key_cache_scoreboard sb = new();

    // idle percentages of the sender and the receiver
    int          send_idle   = 0;
    int          recv_idle   = 0;
    int unsigned cycle_count = 0;

    random_replacement_key_cache_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // watchdog: a hung block ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stalls at random, one draw per cycle
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle);

    // handshake monitor: responses are checked, accepted requests predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_response(out_rsp);
            if (in_valid && in_ready)
                sb.note_request(in_req);
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // present one request and hold it until accepted; valid stays high on
    // return so back-to-back requests need no gap
    task automatic send_request(logic [rrkc_pkg::KEY_W-1:0] k,
                                logic [rrkc_pkg::PICK_W-1:0] pick);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        in_req.key         <= k;
        in_req.random_pick <= pick;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drain every outstanding request, then write the capacity register
    task automatic write_capacity(logic [rrkc_pkg::CAP_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        sb.capacity   = value;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [rrkc_pkg::KEY_W-1:0] key_pool[POOL_MAX];
        logic [rrkc_pkg::CAP_W-1:0] cap_plan[8];
        logic [rrkc_pkg::KEY_W-1:0] k;
        int                         pool_size;
        int                         chunk_no;

        cap_plan = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd2, 5'd5, 5'd17, 5'd9};

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_req    = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 24;
        recv_idle = 82;

        // directed: fill from empty at reset capacity, extremes of key and pick
        send_request(16'h0000, 16'h0000);
        send_request(16'hffff, 16'hffff);
        send_request(16'h0000, 16'h1234);    // hit on key zero
        send_request(16'hffff, 16'h0000);    // hit on all-ones key
        send_request(16'h1234, 16'habcd);
        send_request(16'h8001, 16'h5555);

        // capacity lowered below the fill count: each miss evicts one key
        write_capacity(5'd2);
        send_request(16'h5555, 16'hffff);    // victim falls on the last slot
        send_request(16'haaaa, 16'h0002);
        send_request(16'haaaa, 16'h0000);

        // capacity zero: misses store nothing, stored keys still hit
        write_capacity(5'd0);
        send_request(16'h7777, 16'h0001);
        send_request(16'h5555, 16'h0000);
        send_request(16'h7777, 16'hffff);

        // capacity above the slot count saturates
        write_capacity(5'd31);
        for (int i = 0; i < 5; i++)
            send_request(rrkc_pkg::KEY_W'(16'h0100 + i), rrkc_pkg::PICK_W'(i * 16'h3333));

        // back down to one slot with a larger fill count
        write_capacity(5'd1);
        send_request(16'hffff, 16'hffff);
        send_request(16'h4242, 16'h0003);
        send_request(16'h0001, 16'h0000);
        send_request(16'h0001, 16'h8000);

        // random: three idling profiles, capacity changed between chunks
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin send_idle = 24; recv_idle = 82; end
                1:       begin send_idle = 82; recv_idle = 24; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            for (int c = 0; c < CHUNKS; c++)
            begin
                chunk_no = phase * CHUNKS + c;
                write_capacity((chunk_no < 8) ? cap_plan[chunk_no]
                                              : rrkc_pkg::CAP_W'($urandom_range(0, 31)));
                // small key pools give hits, large ones misses and evictions
                pool_size = $urandom_range(2, POOL_MAX);
                for (int i = 0; i < POOL_MAX; i++)
                    key_pool[i] = rrkc_pkg::KEY_W'($urandom_range(0, 65535));
                if ($urandom_range(0, 3) == 0)
                begin
                    key_pool[0] = '1;
                    key_pool[1] = '0;
                end
                for (int n = 0; n < CHUNK_ITEMS; n++)
                begin
                    if ($urandom_range(0, 99) < 15)
                        k = rrkc_pkg::KEY_W'($urandom_range(0, 65535));
                    else
                        k = key_pool[$urandom_range(0, pool_size - 1)];
                    send_request(k, rrkc_pkg::PICK_W'($urandom_range(0, 65535)));
                end
            end
        end

        // drain and give the block time to show any stray response
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
